[design/wlfq_pkg.sv]
// Shared types, widths and codes for the weight-limited drop-oldest FIFO.
`timescale 1ns / 1ps
`default_nettype none

package wlfq_pkg;

  localparam int REQ_W      = 2;
  localparam int ID_W       = 16;
  localparam int WEIGHT_W   = 16;
  localparam int SUM_W      = 20;
  localparam int KIND_W     = 3;
  localparam int OCC_W      = 5;
  localparam int CFG_IDX_W  = 1;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int RESULT_LIMIT        = 17;
  localparam int POP_W               = $clog2(RESULT_LIMIT + 1);

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEPART = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_DISPATCH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LIMIT  = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_DEPART,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE   = 3'd0,
    EV_DEPART = 3'd1,
    EV_AUTO   = 3'd2,
    EV_CLEAR  = 3'd3,
    EV_REJECT = 3'd4,
    EV_EMPTY  = 3'd5
  } kind_t;

  typedef struct packed {
    op_t                 op;
    logic [ID_W-1:0]     item_id;
    logic [WEIGHT_W-1:0] item_weight;
  } cmd_t;

  typedef struct packed {
    logic             auto_en;
    logic [SUM_W-1:0] weight_limit;
  } cfg_t;

endpackage

`default_nettype wire

[design/wlfq_if.sv]
// Valid/ready channel interfaces for request and result words.
`timescale 1ns / 1ps
`default_nettype none

interface wlfq_in_if;
  logic                          valid;
  logic                          ready;
  logic [wlfq_pkg::REQ_W-1:0]    req_type;
  logic [wlfq_pkg::ID_W-1:0]     item_id;
  logic [wlfq_pkg::WEIGHT_W-1:0] item_weight;

  modport source (output valid, output req_type, output item_id, output item_weight,
                  input ready);
  modport sink (input valid, input req_type, input item_id, input item_weight,
                output ready);
endinterface

interface wlfq_out_if;
  logic                          valid;
  logic                          ready;
  logic [wlfq_pkg::KIND_W-1:0]   event_kind;
  logic [wlfq_pkg::ID_W-1:0]     out_id;
  logic [wlfq_pkg::WEIGHT_W-1:0] out_weight;
  logic [wlfq_pkg::SUM_W-1:0]    total_weight;
  logic [wlfq_pkg::OCC_W-1:0]    occupancy;
  logic                          last;

  modport source (output valid, output event_kind, output out_id, output out_weight,
                  output total_weight, output occupancy, output last, input ready);
  modport sink (input valid, input event_kind, input out_id, input out_weight,
                input total_weight, input occupancy, input last, output ready);
endinterface

`default_nettype wire

[design/weight_limited_fifo_drop_oldest_top.sv]
// Top level of the weight-limited FIFO with drop-oldest auto-dispatch.
//
// in_chan carries request words (add, depart, clear) on valid/ready; out_chan
// carries result words, one per popped entry or one status word, with last
// set on the final word of each request. cfg_we/cfg_index/cfg_data write the
// auto-dispatch enable (index 0) and the weight limit (index 1); the user
// must do so only while idle, which the block does not enforce. A two-entry
// command queue sits between the request decoder and the executing back end,
// and a result register parts the back end from out_chan.
// A status-only word passes the command queue and the result register; a pop
// word also passes the back end's pop state, which waits on the entry store.
// While out_chan is ready, one status-only request is taken per cycle and
// pops follow at one per cycle; the next request waits for the last pop.
// Reset empties the queue, zeroes the total weight and clears both config
// registers; no clearing pass is needed. When out_chan stalls, the back end
// holds its word and the command queue fills, then in_chan drops ready.
`timescale 1ns / 1ps
`default_nettype none

module weight_limited_fifo_drop_oldest_top #(
  parameter int QUEUE_DEPTH = wlfq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  wlfq_in_if.sink                                in_chan,
  wlfq_out_if.source                             out_chan,
  input  wire logic                              cfg_we,
  input  wire logic [wlfq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [wlfq_pkg::SUM_W-1:0]        cfg_data
);

  wlfq_pkg::cfg_t cfg_r;
  logic           cmd_valid;
  wlfq_pkg::cmd_t cmd;
  logic           cmd_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wlfq_pkg::CFG_AUTO_DISPATCH: cfg_r.auto_en      <= cfg_data[0];
        wlfq_pkg::CFG_WEIGHT_LIMIT:  cfg_r.weight_limit <= cfg_data;
        default:                     cfg_r              <= cfg_r;
      endcase
    end
  end

  wlfq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  wlfq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

[design/wlfq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module wlfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[design/wlfq_front.sv]
// Front end: accepts request words, decodes them and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module wlfq_front (
  input  wire logic     clk,
  input  wire logic     rst_n,
  wlfq_in_if.sink       in_chan,
  output logic          cmd_valid,
  output wlfq_pkg::cmd_t cmd,
  input  wire logic     cmd_pop
);

  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  wlfq_pkg::cmd_t   q_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r;
  logic [CQ_AW-1:0] rd_ptr_r;
  logic [CQ_CW-1:0] fill_r;
  wlfq_pkg::cmd_t   dec_cmd;
  logic             push;

  always_comb begin
    dec_cmd.item_id     = in_chan.item_id;
    dec_cmd.item_weight = in_chan.item_weight;
    case (in_chan.req_type)
      wlfq_pkg::REQ_ADD:    dec_cmd.op = wlfq_pkg::OP_ADD;
      wlfq_pkg::REQ_DEPART: dec_cmd.op = wlfq_pkg::OP_DEPART;
      wlfq_pkg::REQ_CLEAR:  dec_cmd.op = wlfq_pkg::OP_CLEAR;
      default:              dec_cmd.op = wlfq_pkg::OP_NOP;
    endcase
  end

  assign in_chan.ready = (fill_r != CQ_CW'(CQ_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign cmd_valid     = (fill_r != '0);
  assign cmd           = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, cmd_pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/wlfq_back.sv]
// Back end: runs commands against the entry store and drives result words.
`timescale 1ns / 1ps
`default_nettype none

module wlfq_back #(
  parameter int QUEUE_DEPTH = wlfq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire wlfq_pkg::cfg_t cfg,
  input  wire logic           cmd_valid,
  input  wire wlfq_pkg::cmd_t cmd,
  output logic                cmd_pop,
  wlfq_out_if.source          out_chan
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_W = wlfq_pkg::ID_W + wlfq_pkg::WEIGHT_W;
  localparam int SW    = wlfq_pkg::SUM_W;
  localparam int PW    = wlfq_pkg::POP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [SW-1:0]   sum_r, sum_nxt;
  logic [PW-1:0]   pops_r, pops_nxt;
  wlfq_pkg::kind_t kind_r, kind_nxt;

  logic                            out_valid_r;
  logic [wlfq_pkg::KIND_W-1:0]     out_kind_r;
  logic [wlfq_pkg::ID_W-1:0]       out_id_r;
  logic [wlfq_pkg::WEIGHT_W-1:0]   out_weight_r;
  logic [SW-1:0]                   out_total_r;
  logic [CW-1:0]                   out_count_r;
  logic                            out_last_r;

  logic                            emit;
  wlfq_pkg::kind_t                 emit_kind;
  logic [wlfq_pkg::ID_W-1:0]       emit_id;
  logic [wlfq_pkg::WEIGHT_W-1:0]   emit_weight;
  logic [SW-1:0]                   emit_total;
  logic [CW-1:0]                   emit_count;
  logic                            emit_last;

  logic                            out_free;
  logic [AW:0]                     tail_sum;
  logic [AW:0]                     tail_wrap;
  logic [AW-1:0]                   tail_idx;
  logic [AW-1:0]                   head_inc;
  logic [SW:0]                     add_sum;
  logic                            full;
  logic                            ram_we;
  logic [MEM_W-1:0]                rd_data;
  logic [wlfq_pkg::ID_W-1:0]       pop_id;
  logic [wlfq_pkg::WEIGHT_W-1:0]   pop_weight;
  logic [SW-1:0]                   pop_sum;
  logic [CW-1:0]                   pop_count;
  logic [PW-1:0]                   pops_inc;
  logic                            more;

  assign out_free  = !out_valid_r || out_chan.ready;
  assign tail_sum  = {1'b0, head_r} + (AW+1)'(count_r);
  assign tail_wrap = tail_sum - (AW+1)'(QUEUE_DEPTH);
  assign tail_idx  = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ? tail_wrap[AW-1:0]
                                                         : tail_sum[AW-1:0];
  assign head_inc  = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign add_sum   = {1'b0, sum_r} + (SW+1)'(cmd.item_weight);
  assign full      = (count_r == CW'(QUEUE_DEPTH));

  assign pop_id     = rd_data[MEM_W-1:wlfq_pkg::WEIGHT_W];
  assign pop_weight = rd_data[wlfq_pkg::WEIGHT_W-1:0];
  assign pop_sum    = sum_r - SW'(pop_weight);
  assign pop_count  = count_r - 1'b1;
  assign pops_inc   = pops_r + 1'b1;

  // Read address follows the next head, so the read data is the registered head entry.
  wlfq_ram #(
    .WIDTH (MEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_idx),
    .wdata ({cmd.item_id, cmd.item_weight}),
    .raddr (head_nxt),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    pops_nxt    = pops_r;
    kind_nxt    = kind_r;
    cmd_pop     = 1'b0;
    ram_we      = 1'b0;
    emit        = 1'b0;
    emit_kind   = wlfq_pkg::EV_NONE;
    emit_id     = '0;
    emit_weight = '0;
    emit_total  = sum_r;
    emit_count  = count_r;
    emit_last   = 1'b1;
    more        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            wlfq_pkg::OP_ADD: begin
              if (full || add_sum[SW]) begin
                emit      = 1'b1;
                emit_kind = wlfq_pkg::EV_REJECT;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + 1'b1;
                sum_nxt   = add_sum[SW-1:0];
                if (cfg.auto_en && (add_sum[SW-1:0] > cfg.weight_limit)) begin
                  kind_nxt  = wlfq_pkg::EV_AUTO;
                  pops_nxt  = '0;
                  state_nxt = S_POP;
                end else begin
                  emit       = 1'b1;
                  emit_kind  = wlfq_pkg::EV_NONE;
                  emit_total = add_sum[SW-1:0];
                  emit_count = count_r + 1'b1;
                end
              end
            end
            wlfq_pkg::OP_DEPART: begin
              if (count_r == '0) begin
                emit      = 1'b1;
                emit_kind = wlfq_pkg::EV_EMPTY;
              end else begin
                kind_nxt  = wlfq_pkg::EV_DEPART;
                pops_nxt  = '0;
                state_nxt = S_POP;
              end
            end
            wlfq_pkg::OP_CLEAR: begin
              if (count_r == '0) begin
                emit      = 1'b1;
                emit_kind = wlfq_pkg::EV_NONE;
              end else begin
                kind_nxt  = wlfq_pkg::EV_CLEAR;
                pops_nxt  = '0;
                state_nxt = S_POP;
              end
            end
            default: begin
              emit      = 1'b1;
              emit_kind = wlfq_pkg::EV_NONE;
            end
          endcase
        end
      end
      S_POP: begin
        // wait here for the head entry to come out of the store
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_kind   = kind_r;
          emit_id     = pop_id;
          emit_weight = pop_weight;
          emit_total  = pop_sum;
          emit_count  = pop_count;
          head_nxt    = head_inc;
          count_nxt   = pop_count;
          sum_nxt     = pop_sum;
          pops_nxt    = pops_inc;
          case (kind_r)
            wlfq_pkg::EV_AUTO:
              more = (pop_sum > cfg.weight_limit) && (pop_count != '0) &&
                     (pops_inc < PW'(wlfq_pkg::RESULT_LIMIT));
            wlfq_pkg::EV_CLEAR:
              more = (pop_count != '0) && (pops_inc < PW'(wlfq_pkg::RESULT_LIMIT));
            default:
              more = 1'b0;
          endcase
          emit_last = !more;
          if (!more) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      pops_r      <= '0;
      kind_r      <= wlfq_pkg::EV_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      pops_r  <= pops_nxt;
      kind_r  <= kind_nxt;
      if (emit) begin
        out_valid_r  <= 1'b1;
        out_kind_r   <= emit_kind;
        out_id_r     <= emit_id;
        out_weight_r <= emit_weight;
        out_total_r  <= emit_total;
        out_count_r  <= emit_count;
        out_last_r   <= emit_last;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.event_kind   = out_kind_r;
  assign out_chan.out_id       = out_id_r;
  assign out_chan.out_weight   = out_weight_r;
  assign out_chan.total_weight = out_total_r;
  assign out_chan.occupancy    = wlfq_pkg::OCC_W'(out_count_r);
  assign out_chan.last         = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_empty_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (sum_r == '0))
    else $error("empty queue with nonzero total weight");

  a_pop_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pops_r <= PW'(wlfq_pkg::RESULT_LIMIT))
    else $error("too many pops for one request");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (count_r != '0))
    else $error("pop attempted on empty queue");

endmodule

`default_nettype wire
